// File: src/constant_time_median_filter_macros.svh
// ---------------------------------------------------------------------------
// Median filter assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ---------------------------------------------------------------------------
`ifndef CONSTANT_TIME_MEDIAN_FILTER_MACROS_SVH
`define CONSTANT_TIME_MEDIAN_FILTER_MACROS_SVH

// same-cycle implication
`define CMF_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/cmf_pkg.sv
// ---------------------------------------------------------------------------
// Median filter package
// Shared constants, types and small tables of the median filter.
// ---------------------------------------------------------------------------
package cmf_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned StoreRows = 15;
  localparam int unsigned ColW      = 10;
  localparam int unsigned RowW      = 12;
  localparam int unsigned SlotW     = 4;
  localparam int unsigned AddrW     = SlotW + ColW;
  localparam int unsigned PixW      = 24;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DRAIN,
    ST_DECIDE,
    ST_OUT
  } back_state_e;

  typedef struct packed {
    logic [2:0]  radius;
    logic [10:0] width;
    logic [12:0] height;
  } cfg_t;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic [ColW-1:0]  x;
    logic [2:0]       r;
    logic [RowW-1:0]  crow;
    logic [ColW-1:0]  ccol;
  } job_t;

  typedef struct packed {
    logic busy;
  } back_status_t;

  function automatic logic [6:0] middle_of(input logic [2:0] r);
    logic [6:0] m;
    case (r)
      3'd0:    m = 7'd0;
      3'd1:    m = 7'd4;
      3'd2:    m = 7'd12;
      3'd3:    m = 7'd24;
      3'd4:    m = 7'd40;
      3'd5:    m = 7'd60;
      3'd6:    m = 7'd84;
      default: m = 7'd112;
    endcase
    return m;
  endfunction

endpackage

// File: src/constant_time_median_filter.sv
// ---------------------------------------------------------------------------
// Constant time median filter
// RGB square-window median filter over a raster pixel stream.
// ---------------------------------------------------------------------------
// Pixels enter on the s_ channel in raster order, s_tuser_i marking the first
// pixel of a frame. Each pixel is written to a 15-row line store. A pixel that
// completes a (2r+1) square window queues a job; the back end reads the window
// from the line store once per result bit (8 passes) and emits the per-channel
// medians with the window centre on the m_ channel.
// A pixel that completes no window does not hold off the next one. A pixel that
// completes one holds off the next pixel until the back end, through the single
// line-store read port, has scanned the window and reached its output state.
// The output register holds a result while the receiver stalls; the next
// pixel is still taken, and its scan waits only for the register to free.
// Reset clears position, queue and output; registers reload radius 1,
// width 640, height 480. The line store is not cleared.
// Registers are written over APB at 0x0 (radius), 0x4 (width), 0x8 (height).
// ---------------------------------------------------------------------------
module constant_time_median_filter import cmf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [23:0] s_tdata_i,   // red_in, green_in, blue_in
  input  logic        s_tuser_i,   // frame_start
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [47:0] m_tdata_o,   // red, green, blue median, centre_row, centre_col
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t             cfg_q;
  logic             wr_en, push, q_empty, pop;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [PixW-1:0]  wr_data, rd_data;
  job_t             push_job, pop_job;
  back_status_t     status;
  reg_idx_e         idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius <= 3'd1;
      cfg_q.width  <= 11'd640;
      cfg_q.height <= 13'd480;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_RADIUS: cfg_q.radius <= pwdata[2:0];
        REG_WIDTH:  cfg_q.width  <= pwdata[10:0];
        REG_HEIGHT: cfg_q.height <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RADIUS: prdata = {29'd0, cfg_q.radius};
      REG_WIDTH:  prdata = {21'd0, cfg_q.width};
      REG_HEIGHT: prdata = {19'd0, cfg_q.height};
      default:    prdata = '0;
    endcase
  end

  cmf_front u_front (
    .clk_i, .rst_ni,
    .cfg_i     (cfg_q),
    .s_tvalid_i, .s_tready_o, .s_tdata_i, .s_tuser_i,
    .q_empty_i (q_empty),
    .status_i  (status),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .push_o    (push),
    .job_o     (push_job)
  );

  cmf_ram #(.Width(PixW), .Depth(StoreRows * MaxWidth)) u_store (
    .clk_i,
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  cmf_queue u_queue (
    .clk_i, .rst_ni,
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .empty_o     (q_empty)
  );

  cmf_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i (!q_empty),
    .job_i       (pop_job),
    .job_pop_o   (pop),
    .status_o    (status),
    .rd_addr_o   (rd_addr),
    .rd_data_i   (rd_data),
    .m_tvalid_o, .m_tready_i, .m_tdata_o
  );

endmodule

// File: src/cmf_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module cmf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/cmf_queue.sv
// ---------------------------------------------------------------------------
// Job queue
// Two-entry queue of window jobs between front and back.
// ---------------------------------------------------------------------------
module cmf_queue import cmf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  input  logic pop_i,
  output job_t pop_data_o,
  output logic empty_o
);

  job_t       ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i && cnt_q != 2'd2) begin
      ent_q[wp_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i && cnt_q != 2'd2) wp_q <= ~wp_q;
      if (pop_i && cnt_q != 2'd0) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'((push_i && cnt_q != 2'd2) ? 1 : 0)
                     - 2'((pop_i && cnt_q != 2'd0) ? 1 : 0);
    end
  end

  assign pop_data_o = ent_q[rp_q];
  assign empty_o    = (cnt_q == 2'd0);

endmodule

// File: src/cmf_front.sv
// ---------------------------------------------------------------------------
// Median filter front end
// Track pixel position, store pixels and queue a job per complete window.
// ---------------------------------------------------------------------------
module cmf_front import cmf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             s_tvalid_i,
  output logic             s_tready_o,
  input  logic [23:0]      s_tdata_i,
  input  logic             s_tuser_i,
  input  logic             q_empty_i,
  input  back_status_t     status_i,
  output logic             wr_en_o,
  output logic [AddrW-1:0] wr_addr_o,
  output logic [PixW-1:0]  wr_data_o,
  output logic             push_o,
  output job_t             job_o
);

  logic [RowW-1:0]  row_q, row_d;
  logic [ColW-1:0]  col_q, col_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [10:0]      weff;
  logic [12:0]      heff;
  logic [RowW-1:0]  y;
  logic [ColW-1:0]  x;
  logic [SlotW-1:0] slot;
  logic [12:0]      twor;
  logic             hit, acc;

  always_comb begin
    weff = (cfg_i.width > 11'd1024) ? 11'd1024 : cfg_i.width;
    if (weff == 11'd0) weff = 11'd1;
    heff = (cfg_i.height > 13'd4096) ? 13'd4096 : cfg_i.height;
    if (heff == 13'd0) heff = 13'd1;
  end

  assign s_tready_o = q_empty_i && !status_i.busy;
  assign acc        = s_tvalid_i && s_tready_o;
  assign y          = s_tuser_i ? '0 : row_q;
  assign x          = s_tuser_i ? '0 : col_q;
  assign slot       = s_tuser_i ? '0 : slot_q;
  assign twor       = {9'd0, cfg_i.radius, 1'b0};

  assign hit = ({1'b0, y} < heff) && ({1'b0, x} < weff)
            && ({1'b0, y} >= twor) && ({3'd0, x} >= twor);

  assign wr_en_o   = acc;
  assign wr_addr_o = {slot, x};
  assign wr_data_o = s_tdata_i;
  assign push_o    = acc && hit;

  always_comb begin
    job_o.slot = slot;
    job_o.x    = x;
    job_o.r    = cfg_i.radius;
    job_o.crow = y - RowW'(cfg_i.radius);
    job_o.ccol = x - ColW'(cfg_i.radius);
  end

  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    slot_d = slot_q;
    if (acc) begin
      if ({1'b0, x} + 11'd1 >= weff) begin
        col_d = '0;
        if ({1'b0, y} + 13'd1 >= heff) begin
          row_d  = '0;
          slot_d = '0;
        end else begin
          row_d  = y + 12'd1;
          slot_d = (slot == SlotW'(StoreRows - 1)) ? '0 : slot + 4'd1;
        end
      end else begin
        row_d  = y;
        slot_d = slot;
        col_d  = x + 10'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      slot_q <= '0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      slot_q <= slot_d;
    end
  end

endmodule

// File: src/cmf_back.sv
// ---------------------------------------------------------------------------
// Median filter back end
// Scan each queued window bit by bit for the per-channel median.
// ---------------------------------------------------------------------------
`include "constant_time_median_filter_macros.svh"

module cmf_back import cmf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  job_t             job_i,
  output logic             job_pop_o,
  output back_status_t     status_o,
  output logic [AddrW-1:0] rd_addr_o,
  input  logic [PixW-1:0]  rd_data_i,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [47:0]      m_tdata_o
);

  back_state_e      st_q, st_d;
  job_t             job_q, job_d;
  logic [3:0]       dx_q, dx_d, dy_q, dy_d;
  logic [SlotW-1:0] rslot_q, rslot_d;
  logic [ColW-1:0]  col_q, col_d;
  logic             rd_vld_q;
  logic [7:0]       cnt_q [3];
  logic [7:0]       cnt_d [3];
  logic [7:0]       pre_q [3];
  logic [7:0]       pre_d [3];
  logic [6:0]       k_q [3];
  logic [6:0]       k_d [3];
  logic [7:0]       mask_q, mask_d, bsel_q, bsel_d;
  logic             oval_q, oval_d;
  logic [47:0]      odata_q, odata_d;
  logic [3:0]       span;
  logic [7:0]       smp;

  assign span      = {job_q.r, 1'b1};
  assign rd_addr_o = {rslot_q, col_q};
  assign status_o.busy = (st_q == ST_READ) || (st_q == ST_DRAIN) || (st_q == ST_DECIDE);
  assign m_tvalid_o = oval_q;
  assign m_tdata_o  = odata_q;

  always_comb begin
    st_d      = st_q;
    job_d     = job_q;
    dx_d      = dx_q;
    dy_d      = dy_q;
    rslot_d   = rslot_q;
    col_d     = col_q;
    mask_d    = mask_q;
    bsel_d    = bsel_q;
    oval_d    = oval_q;
    odata_d   = odata_q;
    job_pop_o = 1'b0;
    smp       = '0;
    for (int c = 0; c < 3; c++) begin
      cnt_d[c] = cnt_q[c];
      pre_d[c] = pre_q[c];
      k_d[c]   = k_q[c];
    end
    if (oval_q && m_tready_i) oval_d = 1'b0;
    if (rd_vld_q) begin
      for (int c = 0; c < 3; c++) begin
        smp = rd_data_i[8*c +: 8];
        if ((((smp ^ pre_q[c]) & mask_q) == 8'd0) && ((smp & bsel_q) == 8'd0)) begin
          cnt_d[c] = cnt_q[c] + 8'd1;
        end
      end
    end
    case (st_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          rslot_d   = job_i.slot;
          col_d     = job_i.x;
          dx_d      = '0;
          dy_d      = '0;
          mask_d    = '0;
          bsel_d    = 8'h80;
          for (int c = 0; c < 3; c++) begin
            cnt_d[c] = '0;
            pre_d[c] = '0;
            k_d[c]   = middle_of(job_i.r);
          end
          st_d = ST_READ;
        end
      end
      ST_READ: begin
        if (dx_q == span - 4'd1) begin
          dx_d    = '0;
          col_d   = job_q.x;
          dy_d    = dy_q + 4'd1;
          rslot_d = (rslot_q == '0) ? SlotW'(StoreRows - 1) : rslot_q - 4'd1;
          if (dy_q == span - 4'd1) st_d = ST_DRAIN;
        end else begin
          dx_d  = dx_q + 4'd1;
          col_d = col_q - 10'd1;
        end
      end
      ST_DRAIN: begin
        st_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        for (int c = 0; c < 3; c++) begin
          if ({1'b0, k_q[c]} >= cnt_q[c]) begin
            pre_d[c] = pre_q[c] | bsel_q;
            k_d[c]   = k_q[c] - cnt_q[c][6:0];
          end
          cnt_d[c] = '0;
        end
        mask_d  = {1'b1, mask_q[7:1]};
        bsel_d  = {1'b0, bsel_q[7:1]};
        rslot_d = job_q.slot;
        col_d   = job_q.x;
        dx_d    = '0;
        dy_d    = '0;
        st_d    = bsel_q[0] ? ST_OUT : ST_READ;
      end
      ST_OUT: begin
        if (!oval_q || m_tready_i) begin
          oval_d  = 1'b1;
          odata_d = {2'b00, job_q.ccol, job_q.crow, pre_q[2], pre_q[1], pre_q[0]};
          st_d    = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    rslot_q <= rslot_d;
    col_q   <= col_d;
    mask_q  <= mask_d;
    bsel_q  <= bsel_d;
    odata_q <= odata_d;
    for (int c = 0; c < 3; c++) begin
      cnt_q[c] <= cnt_d[c];
      pre_q[c] <= pre_d[c];
      k_q[c]   <= k_d[c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      rd_vld_q <= 1'b0;
      oval_q   <= 1'b0;
    end else begin
      st_q     <= st_d;
      rd_vld_q <= (st_q == ST_READ);
      oval_q   <= oval_d;
    end
  end

  `CMF_ASSERT(a_drain_after_read, st_q == ST_DRAIN, $past(st_q) == ST_READ, "drain without read")
  `CMF_ASSERT(a_read_in_window, st_q == ST_READ, dy_q < span && dx_q < span, "scan outside window")
  `CMF_ASSERT_NEXT(a_out_loads, st_q == ST_OUT && (!oval_q || m_tready_i), oval_q && st_q == ST_IDLE,
                   "result not loaded")

endmodule
